// ===== rtl/rdw_pkg.sv =====
// ----------------------------------------------------------------------------
// Reverse delay package
// Shared constants, configuration register codes and the sequencer microcode
// for the reverse delay block.
// ----------------------------------------------------------------------------
package rdw_pkg;

  localparam int MAX_DELAY_DEF   = 131072;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int POS_BITS       = 17;
  localparam int DLEN_BITS      = 18;
  localparam int RAMP_BITS      = 16;
  localparam int WSTEP_BITS     = 24;
  localparam int GAIN_BITS      = 16;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int UC_ADDR_BITS   = 3;

  localparam logic [WSTEP_BITS-1:0] ONE_Q23 = 24'h80_0000;
  localparam logic [GAIN_BITS:0]    ONE_Q15 = 17'h0_8000;

  localparam logic [DLEN_BITS-1:0]  DLEN_RST  = 18'd24000;
  localparam logic [RAMP_BITS-1:0]  RAMP_RST  = 16'd2970;
  localparam logic [WSTEP_BITS-1:0] WSTEP_RST = 24'd2824;
  localparam logic [GAIN_BITS-1:0]  FB_RST    = 16'd0;
  localparam logic [GAIN_BITS-1:0]  MIX_RST   = 16'd16384;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY_LENGTH  = 3'd0,
    REG_RAMP_LENGTH   = 3'd1,
    REG_WINDOW_STEP   = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_MIX_GAIN      = 3'd4
  } reg_idx_e;

  typedef enum logic [UC_ADDR_BITS-1:0] {
    UC_IDLE    = 3'd0,
    UC_FB_MUL  = 3'd1,
    UC_STORE   = 3'd2,
    UC_DRY_MUL = 3'd3,
    UC_WET_MUL = 3'd4,
    UC_OUT     = 3'd5
  } uc_addr_e;

  typedef enum logic [1:0] {J_NEXT, J_WAIT_IN, J_WAIT_OUT, J_GOTO} jmp_e;
  typedef enum logic [1:0] {A_NONE, A_FBS, A_X, A_WET} asel_e;
  typedef enum logic [2:0] {B_NONE, B_FB, B_W, B_DRY, B_MIX} bsel_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_e;

  typedef struct packed {
    jmp_e     jmp;
    uc_addr_e target;
    asel_e    asel;
    bsel_e    bsel;
    acc_e     acc;
    logic     ld_in;
    logic     ld_fbs;
    logic     st_wr;
    logic     ld_wet;
    logic     ld_out;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } sts_t;

  function automatic ucode_t rdw_ucode(input logic [UC_ADDR_BITS-1:0] addr);
    ucode_t uc;
    uc.jmp    = J_NEXT;
    uc.target = UC_IDLE;
    uc.asel   = A_NONE;
    uc.bsel   = B_NONE;
    uc.acc    = ACC_HOLD;
    uc.ld_in  = 1'b0;
    uc.ld_fbs = 1'b0;
    uc.st_wr  = 1'b0;
    uc.ld_wet = 1'b0;
    uc.ld_out = 1'b0;
    case (addr)
      UC_IDLE: begin
        uc.jmp    = J_WAIT_IN;
        uc.target = UC_FB_MUL;
        uc.ld_in  = 1'b1;
      end
      UC_FB_MUL: begin
        uc.asel   = A_FBS;
        uc.bsel   = B_FB;
        uc.acc    = ACC_LOAD;
        uc.ld_fbs = 1'b1;
      end
      UC_STORE: begin
        uc.asel  = A_FBS;
        uc.bsel  = B_W;
        uc.acc   = ACC_LOAD;
        uc.st_wr = 1'b1;
      end
      UC_DRY_MUL: begin
        uc.asel   = A_X;
        uc.bsel   = B_DRY;
        uc.acc    = ACC_LOAD;
        uc.ld_wet = 1'b1;
      end
      UC_WET_MUL: begin
        uc.asel = A_WET;
        uc.bsel = B_MIX;
        uc.acc  = ACC_ADD;
      end
      UC_OUT: begin
        uc.jmp    = J_WAIT_OUT;
        uc.target = UC_IDLE;
        uc.ld_out = 1'b1;
      end
      default: begin
        uc.jmp    = J_GOTO;
        uc.target = UC_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

// ===== rtl/rdw_in_if.sv =====
// ----------------------------------------------------------------------------
// Reverse delay input channel
// Valid/ready channel carrying one input audio sample per transaction.
// ----------------------------------------------------------------------------
interface rdw_in_if #(
  parameter int SAMPLE_BITS = rdw_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/rdw_out_if.sv =====
// ----------------------------------------------------------------------------
// Reverse delay output channel
// Valid/ready channel carrying one mixed sample and its write position.
// ----------------------------------------------------------------------------
interface rdw_out_if #(
  parameter int SAMPLE_BITS = rdw_pkg::SAMPLE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   sample_out;
  logic [rdw_pkg::POS_BITS-1:0]    position;

  modport source (output valid, output sample_out, output position, input ready);
  modport sink   (input valid, input sample_out, input position, output ready);
endinterface

// ===== rtl/reverse_delay_with_window_top.sv =====
// ----------------------------------------------------------------------------
// Reverse delay with window
// Reverse delay audio effect with feedback, trapezoid window and dry/wet mix.
//
// Samples arrive on the in_ch channel and one result per sample leaves on
// out_ch, carrying the mixed sample and the write position used for it.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write them only while no transaction is in flight, as the block does
// not enforce this; unknown indexes are ignored. A microcode sequencer steps
// one shared multiply-accumulate unit through feedback, window and mix
// products. A sample is taken in the idle step, the four products then run on
// the single multiplier, and the output step follows.
// While a result waits for the receiver, the next sample is still taken and
// worked on up to its final step, where the sequencer holds until the
// output register is free.
// After reset the registers hold their defaults, the pointer and window are
// at zero, and the delay store reads as zero above a fill mark that follows
// the write pointer, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module reverse_delay_with_window_top #(
  parameter int MAX_DELAY   = rdw_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = rdw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rdw_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [rdw_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  rdw_in_if.sink                              in_ch,
  rdw_out_if.source                           out_ch
);
  import rdw_pkg::*;

  localparam int LW = $clog2(MAX_DELAY + 1);

  logic [DLEN_BITS-1:0]  dlen_q;
  logic [RAMP_BITS-1:0]  ramp_q;
  logic [WSTEP_BITS-1:0] wstep_q;
  logic [GAIN_BITS-1:0]  fb_q, mix_q;

  logic [LW-1:0]         len;
  logic [WSTEP_BITS-1:0] wstep;
  logic [GAIN_BITS-1:0]  fb, mix;
  logic                  ptr_clr, win_clr;
  logic [WSTEP_BITS-1:0] w;
  logic                  out_free;
  ucode_t                ctrl;
  sts_t                  sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q  <= DLEN_RST;
      ramp_q  <= RAMP_RST;
      wstep_q <= WSTEP_RST;
      fb_q    <= FB_RST;
      mix_q   <= MIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELAY_LENGTH:  dlen_q  <= cfg_wdata_i[DLEN_BITS-1:0];
        REG_RAMP_LENGTH:   ramp_q  <= cfg_wdata_i[RAMP_BITS-1:0];
        REG_WINDOW_STEP:   wstep_q <= cfg_wdata_i[WSTEP_BITS-1:0];
        REG_FEEDBACK_GAIN: fb_q    <= cfg_wdata_i[GAIN_BITS-1:0];
        REG_MIX_GAIN:      mix_q   <= cfg_wdata_i[GAIN_BITS-1:0];
        default:           dlen_q  <= dlen_q;
      endcase
    end
  end

  always_comb begin
    if (32'(dlen_q) < 32'd2) begin
      len = LW'(2);
    end else if (32'(dlen_q) > 32'(MAX_DELAY)) begin
      len = LW'(MAX_DELAY);
    end else begin
      len = LW'(dlen_q);
    end
    wstep   = (wstep_q > ONE_Q23) ? ONE_Q23 : wstep_q;
    fb      = ({1'b0, fb_q} > ONE_Q15) ? GAIN_BITS'(ONE_Q15) : fb_q;
    mix     = ({1'b0, mix_q} > ONE_Q15) ? GAIN_BITS'(ONE_Q15) : mix_q;
    ptr_clr = cfg_we_i && (cfg_idx_i == REG_DELAY_LENGTH);
    win_clr = cfg_we_i && ((cfg_idx_i == REG_DELAY_LENGTH) ||
                           (cfg_idx_i == REG_RAMP_LENGTH));
  end

  assign sts.in_valid = in_ch.valid;
  assign sts.out_free = out_free;
  assign in_ch.ready  = ctrl.ld_in;

  rdw_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctrl_o (ctrl)
  );

  rdw_window #(
    .MAX_DELAY (MAX_DELAY)
  ) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .len_i     (len),
    .ramp_i    (ramp_q),
    .step_i    (wstep),
    .restart_i (win_clr),
    .advance_i (ctrl.ld_in & in_ch.valid),
    .w_o       (w)
  );

  rdw_datapath #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_ch.valid),
    .sample_i    (in_ch.sample_in),
    .len_i       (len),
    .fb_i        (fb),
    .mix_i       (mix),
    .w_i         (w),
    .ptr_clr_i   (ptr_clr),
    .out_ready_i (out_ch.ready),
    .out_free_o  (out_free),
    .out_valid_o (out_ch.valid),
    .sample_o    (out_ch.sample_out),
    .position_o  (out_ch.position)
  );
endmodule

// ===== rtl/rdw_sequencer.sv =====
// ----------------------------------------------------------------------------
// Reverse delay sequencer
// Step counter over the microcode table with conditional waits and jumps.
// ----------------------------------------------------------------------------
module rdw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rdw_pkg::sts_t   sts_i,
  output rdw_pkg::ucode_t ctrl_o
);
  import rdw_pkg::*;

  logic [UC_ADDR_BITS-1:0] step_q, step_d;
  ucode_t                  ctrl;

  always_comb begin
    ctrl   = rdw_ucode(step_q);
    step_d = step_q;
    case (ctrl.jmp)
      J_NEXT:     step_d = step_q + 3'd1;
      J_WAIT_IN:  if (sts_i.in_valid) step_d = ctrl.target;
      J_WAIT_OUT: if (sts_i.out_free) step_d = ctrl.target;
      J_GOTO:     step_d = ctrl.target;
      default:    step_d = UC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= UC_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
endmodule

// ===== rtl/rdw_window.sv =====
// ----------------------------------------------------------------------------
// Reverse delay window generator
// Trapezoid gain window: ramp up, hold at unity, ramp down, then restart.
// ----------------------------------------------------------------------------
module rdw_window #(
  parameter int MAX_DELAY = rdw_pkg::MAX_DELAY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(MAX_DELAY+1)-1:0]   len_i,
  input  logic [rdw_pkg::RAMP_BITS-1:0]    ramp_i,
  input  logic [rdw_pkg::WSTEP_BITS-1:0]   step_i,
  input  logic                             restart_i,
  input  logic                             advance_i,
  output logic [rdw_pkg::WSTEP_BITS-1:0]   w_o
);
  import rdw_pkg::*;

  localparam int LW = $clog2(MAX_DELAY + 1);
  localparam int CW = (LW > RAMP_BITS) ? LW : RAMP_BITS;

  logic [CW-1:0]         count_q, count_d;
  logic [WSTEP_BITS-1:0] level_q, level_d;
  logic [WSTEP_BITS-1:0] w_q, w_d;
  logic [CW-1:0]         f, fm1h, ramp, re, hi;
  logic [WSTEP_BITS:0]   lvl_up;
  logic [WSTEP_BITS-1:0] lvl_up_c, lvl_dn;

  always_comb begin
    f        = CW'(len_i >> 1);
    fm1h     = (f - CW'(1)) >> 1;
    ramp     = CW'(ramp_i);
    re       = (ramp > fm1h) ? fm1h : ramp;
    hi       = f - re;
    lvl_up   = {1'b0, level_q} + {1'b0, step_i};
    lvl_up_c = (lvl_up > {1'b0, ONE_Q23}) ? ONE_Q23 : lvl_up[WSTEP_BITS-1:0];
    lvl_dn   = (level_q > step_i) ? (level_q - step_i) : '0;
    if (count_q < re) begin
      level_d = lvl_up_c;
      w_d     = lvl_up_c;
      count_d = count_q + CW'(1);
    end else if (count_q <= hi) begin
      level_d = level_q;
      w_d     = ONE_Q23;
      count_d = count_q + CW'(1);
    end else if (count_q < f) begin
      level_d = lvl_dn;
      w_d     = lvl_dn;
      count_d = count_q + CW'(1);
    end else begin
      level_d = '0;
      w_d     = level_q;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= '0;
      w_q     <= '0;
    end else if (restart_i) begin
      count_q <= '0;
      level_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
      level_q <= level_d;
      w_q     <= w_d;
    end
  end

  assign w_o = w_q;
endmodule

// ===== rtl/rdw_datapath.sv =====
// ----------------------------------------------------------------------------
// Reverse delay datapath
// Delay store, write pointer, shared multiply-accumulate and output register,
// all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module rdw_datapath #(
  parameter int MAX_DELAY   = rdw_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = rdw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rdw_pkg::ucode_t                 ctrl_i,
  input  logic                            in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic [$clog2(MAX_DELAY+1)-1:0]  len_i,
  input  logic [rdw_pkg::GAIN_BITS-1:0]   fb_i,
  input  logic [rdw_pkg::GAIN_BITS-1:0]   mix_i,
  input  logic [rdw_pkg::WSTEP_BITS-1:0]  w_i,
  input  logic                            ptr_clr_i,
  input  logic                            out_ready_i,
  output logic                            out_free_o,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   sample_o,
  output logic [rdw_pkg::POS_BITS-1:0]    position_o
);
  import rdw_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int AW   = $clog2(MAX_DELAY);
  localparam int LW   = $clog2(MAX_DELAY + 1);
  localparam int AWID = S + 1;
  localparam int BWID = WSTEP_BITS + 1;
  localparam int PW   = AWID + BWID;

  localparam logic signed [PW-1:0] HALF15 = PW'(16384);
  localparam logic signed [PW-1:0] HALF23 = PW'(4194304);
  localparam logic signed [PW-1:0] SMAX   = (PW'(1) <<< (S - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SMIN   = -SMAX - PW'(1);

  logic signed [S-1:0] store_q [MAX_DELAY];

  logic signed [S-1:0]    x_q, fbs_q, rd_q, out_sample_q;
  logic signed [AWID-1:0] wet_q;
  logic signed [PW-1:0]   acc_q;
  logic [AW-1:0]          p_q, wp_q;
  logic [LW-1:0]          hwm_q;
  logic                   rd_ok_q, out_valid_q;
  logic [POS_BITS-1:0]    out_pos_q;

  logic                   accept;
  logic [LW-1:0]          p_cur, p_inc, raddr_l, p_q_inc;
  logic [AW-1:0]          raddr;
  logic                   rd_ok;
  logic signed [AWID-1:0] mul_a;
  logic signed [BWID-1:0] mul_b;
  logic signed [PW-1:0]   prod, rnd15, rnd23, sum_v;
  logic [GAIN_BITS-1:0]   dry;
  logic signed [S-1:0]    v;

  function automatic logic signed [S-1:0] sat_s(input logic signed [PW-1:0] a);
    logic signed [PW-1:0] c;
    c = (a > SMAX) ? SMAX : ((a < SMIN) ? SMIN : a);
    return S'(c);
  endfunction

  assign accept     = ctrl_i.ld_in & in_valid_i;
  assign out_free_o = ~out_valid_q | out_ready_i;

  always_comb begin
    p_cur   = (LW'(wp_q) >= len_i) ? '0 : LW'(wp_q);
    p_inc   = p_cur + LW'(1);
    raddr_l = len_i - LW'(1) - p_cur;
    raddr   = AW'(raddr_l);
    rd_ok   = (p_cur < (len_i - LW'(1))) && (raddr_l < hwm_q);
    p_q_inc = LW'(p_q) + LW'(1);
    dry     = GAIN_BITS'(ONE_Q15 - {1'b0, mix_i});
  end

  always_comb begin
    case (ctrl_i.asel)
      A_FBS:   mul_a = AWID'(fbs_q);
      A_X:     mul_a = AWID'(x_q);
      A_WET:   mul_a = wet_q;
      default: mul_a = '0;
    endcase
    case (ctrl_i.bsel)
      B_FB:    mul_b = BWID'(fb_i);
      B_W:     mul_b = BWID'(w_i);
      B_DRY:   mul_b = BWID'(dry);
      B_MIX:   mul_b = BWID'(mix_i);
      default: mul_b = '0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign rnd15 = (acc_q + HALF15) >>> 15;
  assign rnd23 = (acc_q + HALF23) >>> 23;
  assign sum_v = rnd15 + PW'(x_q);
  assign v     = sat_s(sum_v);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st_wr) begin
      store_q[p_q] <= v;
    end
    if (accept) begin
      rd_q <= store_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_i;
      p_q <= AW'(p_cur);
    end
    case (ctrl_i.acc)
      ACC_LOAD: acc_q <= prod;
      ACC_ADD:  acc_q <= acc_q + prod;
      default:  acc_q <= acc_q;
    endcase
    if (ctrl_i.ld_wet) begin
      wet_q <= AWID'(rnd23);
    end
    if (ctrl_i.ld_out && out_free_o) begin
      out_sample_q <= sat_s(rnd15);
      out_pos_q    <= POS_BITS'(p_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      hwm_q       <= '0;
      fbs_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ptr_clr_i) begin
        wp_q <= '0;
      end else if (accept) begin
        wp_q <= (p_cur == (len_i - LW'(1))) ? '0 : AW'(p_inc);
      end
      if (accept) begin
        rd_ok_q <= rd_ok;
      end
      if (ctrl_i.ld_fbs) begin
        fbs_q <= rd_ok_q ? rd_q : '0;
      end
      if (ctrl_i.st_wr && (p_q_inc > hwm_q)) begin
        hwm_q <= p_q_inc;
      end
      if (ctrl_i.ld_out && out_free_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign position_o  = out_pos_q;
endmodule
